// ----- hw/rtl/rbe_pkg.sv -----
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rbe_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ANG_BITS   = 16;
    localparam int DIST_BITS  = 26;
    localparam int PI_Q13     = 25736;

    // offsets are normalised so the largest magnitude sits in [2^29, 2^30]
    localparam int NORM_MSB   = 29;
    // CORDIC operands are prescaled so the larger magnitude sits in [2^40, 2^41)
    localparam int CORDIC_MSB = 40;
    localparam int CORDIC_DW  = 46;
    localparam int CORDIC_IW  = 33;
    localparam int Z_W        = 34;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // config register indexes
    localparam logic [1:0] CFG_BEACON_X = 2'd0;
    localparam logic [1:0] CFG_BEACON_Y = 2'd1;
    localparam logic [1:0] CFG_BEACON_Z = 2'd2;

    // atan(2^-i) in radians * 2^30, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048576;
            default: v = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/rbe_delay.sv -----
// ----------------------------------------------------------------------------
// rbe_delay
// Enabled shift line that keeps operands aligned with the pipeline.
// ----------------------------------------------------------------------------
module rbe_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[D-1];
endmodule

// ----- hw/rtl/rbe_isqrt.sv -----
// ----------------------------------------------------------------------------
// rbe_isqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module rbe_isqrt #(
    parameter int IW = 54,
    parameter int RW = IW / 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [IW-1:0] i_s,
    output logic [RW:0]   o_root
);
    logic [IW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [RW:0]   r_out;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [IW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [IW:0]   trial;
        logic [IW-1:0] n_rem;
        logic [RW-1:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = i_s;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        always_comb begin
            trial  = ((IW+1)'(root_in) << (B + 1)) | ((IW+1)'(1) << (2 * B));
            n_rem  = rem_in;
            n_root = root_in;
            if ({1'b0, rem_in} >= trial) begin
                n_rem  = rem_in - trial[IW-1:0];
                n_root = root_in | (RW'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    // round up when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= {1'b0, r_root[RW-1]} +
                     ((r_rem[RW-1] > IW'(r_root[RW-1])) ? (RW+1)'(1) : (RW+1)'(0));
        end
    end

    assign o_root = r_out;
endmodule

// ----- hw/rtl/rbe_cordic.sv -----
// ----------------------------------------------------------------------------
// rbe_cordic
// Pipelined CORDIC vectoring unit giving atan2(y, x) in Q30 radians.
// ----------------------------------------------------------------------------
module rbe_cordic #(
    parameter int STAGES = rbe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic signed [rbe_pkg::CORDIC_IW-1:0]       i_x,
    input  logic signed [rbe_pkg::CORDIC_IW-1:0]       i_y,
    output logic signed [rbe_pkg::Z_W-1:0]             o_z
);
    import rbe_pkg::*;

    localparam int IW = CORDIC_IW;
    localparam int DW = CORDIC_DW;

    // prescale detect
    logic signed [IW-1:0] r_ax, r_ay;
    logic [5:0]           r_sh;
    logic                 r_zero_a;
    // prescaled
    logic signed [DW-1:0] r_bx, r_by;
    logic                 r_zero_b;
    // rotation pipeline
    logic signed [DW-1:0]  r_x [STAGES+1];
    logic signed [DW-1:0]  r_y [STAGES+1];
    logic signed [Z_W-1:0] r_z [STAGES+1];
    logic                  r_zf [STAGES+1];

    logic [IW-1:0] mx, my, m;
    logic [5:0]    p;

    always_comb begin
        mx = i_x[IW-1] ? IW'(-i_x) : IW'(i_x);
        my = i_y[IW-1] ? IW'(-i_y) : IW'(i_y);
        m  = mx | my;
        p  = '0;
        for (int i = 0; i < IW; i++) begin
            if (m[i]) p = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax     <= i_x;
            r_ay     <= i_y;
            r_sh     <= 6'(CORDIC_MSB) - p;
            r_zero_a <= (m == '0);
            r_bx     <= DW'(r_ax) <<< r_sh;
            r_by     <= DW'(r_ay) <<< r_sh;
            r_zero_b <= r_zero_a;
            // left half plane: quarter turn first
            if (r_bx < 0) begin
                if (r_by >= 0) begin
                    r_x[0] <= r_by;
                    r_y[0] <= -r_bx;
                    r_z[0] <= HALF_PI_Q30;
                end else begin
                    r_x[0] <= -r_by;
                    r_y[0] <= r_bx;
                    r_z[0] <= -HALF_PI_Q30;
                end
            end else begin
                r_x[0] <= r_bx;
                r_y[0] <= r_by;
                r_z[0] <= '0;
            end
            r_zf[0] <= r_zero_b;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [Z_W-1:0] ATAN = atan_q30(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN;
                end
                r_zf[i+1] <= r_zf[i];
            end
        end
    end

    // atan2(0, 0) is zero
    assign o_z = r_zf[STAGES] ? '0 : r_z[STAGES];
endmodule

// ----- hw/rtl/range_bearing_elevation.sv -----
// ----------------------------------------------------------------------------
// range_bearing_elevation
// Range, bearing and elevation from a body pose to a configured beacon.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_ready) carries body position (Q16.8) and
//    yaw and pitch (Q3.13). Output channel (o_valid / i_ready) returns
//    distance (Q.8), bearing and elevation (Q3.13, saturated to +-pi).
//  - Beacon position is written through i_cfg_we / i_cfg_idx / i_cfg_data
//    while the block is idle; index 3 is ignored.
//  - One transfer per cycle sustained while the receiver accepts results.
//    The elevation path is the longest: offset normalise, 31-bit rounded
//    root for the horizontal distance, then the CORDIC.
//  - The whole pipeline advances on one enable; when the receiver stalls
//    with a result waiting, every stage holds and o_ready drops, so nothing
//    is lost or repeated. Empty slots still move while the output is free.
//  - Reset clears the valid bits and the beacon registers to zero.
// ----------------------------------------------------------------------------
module range_bearing_elevation #(
    parameter int COORD_BITS    = rbe_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = rbe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [COORD_BITS-1:0]                 i_cfg_data,
    // pose in
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_BITS-1:0]          i_pos_x,
    input  logic signed [COORD_BITS-1:0]          i_pos_y,
    input  logic signed [COORD_BITS-1:0]          i_pos_z,
    input  logic signed [rbe_pkg::ANG_BITS-1:0]   i_yaw,
    input  logic signed [rbe_pkg::ANG_BITS-1:0]   i_pitch,
    // result out
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [rbe_pkg::DIST_BITS-1:0]         o_distance,
    output logic signed [rbe_pkg::ANG_BITS-1:0]   o_bearing,
    output logic signed [rbe_pkg::ANG_BITS-1:0]   o_elevation
);
    import rbe_pkg::*;

    localparam int DW   = COORD_BITS + 1;                      // offset width
    localparam int MW   = (DW > DIST_BITS + 1) ? DW : DIST_BITS + 1;
    localparam int WW   = DW + NORM_MSB;                       // shift room
    localparam int SW   = NORM_MSB + 2;                        // scaled offset
    localparam int DQ_IW = 2 * DIST_BITS + 2;                  // distance sum
    localparam int DQ_RW = DQ_IW / 2;
    localparam int HQ_IW = 2 * NORM_MSB + 4;                   // horizontal sum
    localparam int HQ_RW = HQ_IW / 2;
    localparam int LD   = DQ_RW + 1;
    localparam int LH   = HQ_RW + 1;
    localparam int LC   = 3 + CORDIC_STAGES;
    localparam int T_E  = 6 + LH + LC;                         // elevation z ready
    localparam int LAT  = T_E + 1;

    logic en;

    // beacon registers
    logic signed [COORD_BITS-1:0] r_bcn_x, r_bcn_y, r_bcn_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcn_x <= '0;
            r_bcn_y <= '0;
            r_bcn_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BEACON_X: r_bcn_x <= i_cfg_data;
                CFG_BEACON_Y: r_bcn_y <= i_cfg_data;
                CFG_BEACON_Z: r_bcn_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits, one per stage
    logic [LAT:1] r_vld;

    assign en      = !r_vld[LAT] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_valid};
        end
    end

    // stage 1: offsets
    logic signed [DW-1:0]       r_dx, r_dy, r_dz;
    logic signed [ANG_BITS-1:0] r_yaw, r_pitch;
    // stage 2: magnitudes
    logic [DW-1:0]              r_mx, r_my, r_mz, r_mor;
    logic signed [DW-1:0]       r2_dx, r2_dy, r2_dz;
    // stage 3: squares / msb
    logic [2*DIST_BITS-1:0]     r_qx, r_qy, r_qz;
    logic                       r_far;
    logic [5:0]                 r_p;
    logic signed [DW-1:0]       r3_dx, r3_dy, r3_dz;
    // stage 4: sum / scaled offsets
    logic [DQ_IW-1:0]           r_dsum;
    logic signed [SW-1:0]       r_sx, r_sy, r_sz;
    // stage 5, 6: horizontal sum
    logic [HQ_IW-1:0]           r_hqx, r_hqy;
    logic [HQ_IW-1:0]           r_hsum;

    logic [MW-1:0] mx_w, my_w, mz_w;
    logic [5:0]    p;
    logic          shl;
    logic [5:0]    amt;
    logic signed [WW-1:0] ex, ey, ez;
    // scaled magnitudes reach 2^30 after a floor shift of a negative offset
    logic [NORM_MSB+1:0] ahx, ahy;

    always_comb begin
        mx_w = MW'(r_mx);
        my_w = MW'(r_my);
        mz_w = MW'(r_mz);
        p = '0;
        for (int i = 0; i < DW; i++) begin
            if (r_mor[i]) p = 6'(i);
        end
        shl = (r_p <= 6'(NORM_MSB));
        amt = shl ? 6'(NORM_MSB) - r_p : r_p - 6'(NORM_MSB);
        ex  = WW'(r3_dx);
        ey  = WW'(r3_dy);
        ez  = WW'(r3_dz);
        ahx = r_sx[SW-1] ? (NORM_MSB+2)'(-r_sx) : (NORM_MSB+2)'(r_sx);
        ahy = r_sy[SW-1] ? (NORM_MSB+2)'(-r_sy) : (NORM_MSB+2)'(r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= DW'(r_bcn_x) - DW'(i_pos_x);
            r_dy    <= DW'(r_bcn_y) - DW'(i_pos_y);
            r_dz    <= DW'(r_bcn_z) - DW'(i_pos_z);
            r_yaw   <= i_yaw;
            r_pitch <= i_pitch;

            r_mx  <= r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
            r_my  <= r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
            r_mz  <= r_dz[DW-1] ? DW'(-r_dz) : DW'(r_dz);
            r_mor <= (r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx)) |
                     (r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy)) |
                     (r_dz[DW-1] ? DW'(-r_dz) : DW'(r_dz));
            r2_dx <= r_dx;
            r2_dy <= r_dy;
            r2_dz <= r_dz;

            r_qx  <= mx_w[DIST_BITS-1:0] * mx_w[DIST_BITS-1:0];
            r_qy  <= my_w[DIST_BITS-1:0] * my_w[DIST_BITS-1:0];
            r_qz  <= mz_w[DIST_BITS-1:0] * mz_w[DIST_BITS-1:0];
            r_far <= (|mx_w[MW-1:DIST_BITS]) || (|my_w[MW-1:DIST_BITS]) ||
                     (|mz_w[MW-1:DIST_BITS]);
            r_p   <= p;
            r3_dx <= r2_dx;
            r3_dy <= r2_dy;
            r3_dz <= r2_dz;

            // far beacon: force the root above the clamp
            r_dsum <= r_far ? '1 : DQ_IW'(r_qx) + DQ_IW'(r_qy) + DQ_IW'(r_qz);
            r_sx   <= shl ? SW'(ex <<< amt) : SW'(ex >>> amt);
            r_sy   <= shl ? SW'(ey <<< amt) : SW'(ey >>> amt);
            r_sz   <= shl ? SW'(ez <<< amt) : SW'(ez >>> amt);

            r_hqx  <= ahx * ahx;
            r_hqy  <= ahy * ahy;
            r_hsum <= r_hqx + r_hqy;
        end
    end

    // distance root
    logic [DQ_RW:0] dist_root, dist_d;

    rbe_isqrt #(.IW(DQ_IW), .RW(DQ_RW)) u_dist_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r_dsum),
        .o_root (dist_root)
    );

    rbe_delay #(.W(DQ_RW + 1), .D(T_E - 4 - LD)) u_dist_dly (
        .i_clk (i_clk), .i_en (en), .i_d (dist_root), .o_q (dist_d)
    );

    // horizontal distance of the scaled offsets
    logic [HQ_RW:0]       h_root;
    logic signed [SW-1:0] sz_d;

    rbe_isqrt #(.IW(HQ_IW), .RW(HQ_RW)) u_h_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r_hsum),
        .o_root (h_root)
    );

    rbe_delay #(.W(SW), .D(2 + LH)) u_sz_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r_sz), .o_q (sz_d)
    );

    // angle units
    logic signed [Z_W-1:0] z_brg, z_brg_d, z_elv;

    rbe_cordic #(.STAGES(CORDIC_STAGES)) u_brg_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (CORDIC_IW'(r_sx)),
        .i_y   (CORDIC_IW'(r_sy)),
        .o_z   (z_brg)
    );

    rbe_delay #(.W(Z_W), .D(2 + LH)) u_brg_dly (
        .i_clk (i_clk), .i_en (en), .i_d (z_brg), .o_q (z_brg_d)
    );

    rbe_cordic #(.STAGES(CORDIC_STAGES)) u_elv_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (CORDIC_IW'({1'b0, h_root})),
        .i_y   (CORDIC_IW'(sz_d)),
        .o_z   (z_elv)
    );

    logic signed [ANG_BITS-1:0] yaw_d, pitch_d;

    rbe_delay #(.W(ANG_BITS), .D(T_E - 1)) u_yaw_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r_yaw), .o_q (yaw_d)
    );

    rbe_delay #(.W(ANG_BITS), .D(T_E - 1)) u_pitch_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r_pitch), .o_q (pitch_d)
    );

    // output stage: round Q30 to Q3.13, subtract offset, saturate
    localparam int AW = Z_W - 15;
    localparam logic signed [AW-1:0] PI_A = AW'(PI_Q13);

    logic signed [Z_W:0]  zb_r, ze_r;
    logic signed [AW-1:0] ab, ae;
    logic [DIST_BITS-1:0]         r_dist;
    logic signed [ANG_BITS-1:0]   r_brg, r_elv;

    always_comb begin
        zb_r = ((Z_W+1)'(z_brg_d) + (Z_W+1)'(65536)) >>> 17;
        ze_r = ((Z_W+1)'(z_elv)   + (Z_W+1)'(65536)) >>> 17;
        ab   = AW'(zb_r) - AW'(yaw_d);
        ae   = AW'(ze_r) - AW'(pitch_d);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= (dist_d > (DQ_RW+1)'({DIST_BITS{1'b1}})) ? '1 :
                      dist_d[DIST_BITS-1:0];
            r_brg  <= (ab > PI_A) ? ANG_BITS'(PI_Q13) :
                      (ab < -PI_A) ? ANG_BITS'(-PI_Q13) : ANG_BITS'(ab);
            r_elv  <= (ae > PI_A) ? ANG_BITS'(PI_Q13) :
                      (ae < -PI_A) ? ANG_BITS'(-PI_Q13) : ANG_BITS'(ae);
        end
    end

    assign o_distance  = r_dist;
    assign o_bearing   = r_brg;
    assign o_elevation = r_elv;
endmodule
